>>> hw/rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the chunked body decoder: the classified
// byte that travels from front to back, parser phases and result kinds.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// register map (byte address bit 2 selects the register)
	localparam logic REG_CHUNKED = 1'b0;
	localparam logic REG_STREAM  = 1'b1;

	// character codes
	localparam logic [7:0] CHR_ZERO = 8'h30;
	localparam logic [7:0] CHR_CR   = 8'h0d;
	localparam logic [7:0] CHR_LF   = 8'h0a;

	// result kinds
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_MARK = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	// parser phases
	typedef enum logic [2:0] {
		PH_SIZE       = 3'd0,
		PH_SIZE_LF    = 3'd1,
		PH_FIRST      = 3'd2,
		PH_DATA       = 3'd3,
		PH_TRAIL_CR   = 3'd4,
		PH_TRAIL_LF   = 3'd5,
		PH_AFTER_MARK = 3'd6
	} phase_t;

	// received byte with its character class
	typedef struct packed {
		logic [7:0] data;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_white;
		logic       is_lf;
		logic       is_cr;
		logic       is_zero;
	} item_t;

endpackage

>>> hw/rtl/hcbd_front.sv
// ----------------------------------------------------------------------------
// hcbd_front
// Input side: takes one byte per beat and classifies it (hex digit,
// whitespace, CR, LF, '0') before it enters the queue.
// ----------------------------------------------------------------------------
module hcbd_front (
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] rx_byte
	input  logic          q_full,
	output logic          q_push,
	output hcbd_pkg::item_t q_item
);
	import hcbd_pkg::*;

	logic [7:0] b;

	assign b = s_tdata;

	// take a beat whenever the queue has room
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// character classes
	always_comb begin
		q_item          = '0;
		q_item.data     = b;
		q_item.is_zero  = (b == CHR_ZERO);
		q_item.is_cr    = (b == CHR_CR);
		q_item.is_lf    = (b == CHR_LF);
		q_item.is_white = (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) ||
			(b == 8'h0b) || (b == 8'h0c) || (b == 8'h0d);
		if (b >= 8'h30 && b <= 8'h39) begin
			q_item.is_hex  = 1'b1;
			q_item.hex_val = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			q_item.is_hex  = 1'b1;
			q_item.hex_val = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			q_item.is_hex  = 1'b1;
			q_item.hex_val = 4'(b - 8'h37);
		end
	end

endmodule

>>> hw/rtl/hcbd_queue.sv
// ----------------------------------------------------------------------------
// hcbd_queue
// Short first-in first-out queue of classified bytes between the front
// and the parser, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module hcbd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hcbd_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output hcbd_pkg::item_t head_item
);
	import hcbd_pkg::*;

	item_t               slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/hcbd_back.sv
// ----------------------------------------------------------------------------
// hcbd_back
// Chunk parser: walks the size line, data and trailer one classified byte
// per cycle unless the output stalls, loading results into the output register.
// ----------------------------------------------------------------------------
module hcbd_back #(
	parameter int SIZE_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            chunked_en,
	input  logic            stream_en,
	input  logic            clear,
	input  logic            head_valid,
	input  hcbd_pkg::item_t head_item,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     m_tdata,   // [7:0] out_byte, [8] framing_error, zero pad
	output logic [1:0]      m_tuser,   // [1:0] kind
	output logic            m_tlast    // is_last
);
	import hcbd_pkg::*;

	localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

	phase_t               phase_q, phase_d;
	logic [SIZE_BITS-1:0] len_q, len_d;
	logic [SIZE_BITS-1:0] taken_q, taken_d;
	logic [SIZE_BITS-1:0] taken_inc;
	logic                 hex_stop_q, hex_stop_d;
	logic                 saw_cr_q, saw_cr_d;
	logic                 err_q, err_d;
	logic                 err_set;
	logic                 res_valid;
	kind_t                res_kind;
	logic [7:0]           res_byte;
	logic                 res_last;
	logic                 res_err;
	logic                 out_valid_q;
	kind_t                out_kind_q;
	logic [7:0]           out_byte_q;
	logic                 out_err_q;
	logic                 out_last_q;
	item_t                c;

	assign c         = head_item;
	assign pop       = head_valid && (!out_valid_q || m_tready);
	assign taken_inc = taken_q + 1'b1;

	// next state and result of the byte at the queue head
	always_comb begin
		phase_d    = phase_q;
		len_d      = len_q;
		taken_d    = taken_q;
		hex_stop_d = hex_stop_q;
		saw_cr_d   = saw_cr_q;
		err_set    = 1'b0;
		res_valid  = 1'b0;
		res_kind   = KIND_DATA;
		res_byte   = '0;
		res_last   = 1'b0;
		if (!chunked_en) begin
			res_valid = 1'b1;
			res_byte  = c.data;
		end else if (phase_q == PH_AFTER_MARK && c.is_zero) begin
			phase_d    = PH_SIZE;
			len_d      = '0;
			taken_d    = '0;
			hex_stop_d = 1'b0;
			saw_cr_d   = 1'b0;
			res_valid  = 1'b1;
			res_kind   = KIND_END;
			res_last   = 1'b1;
		end else begin
			case (phase_q)
				PH_SIZE, PH_AFTER_MARK, PH_SIZE_LF: begin
					if (phase_q == PH_SIZE_LF || c.is_lf) begin
						// end of the size line
						if (phase_q == PH_SIZE_LF && !(saw_cr_q && c.is_lf)) begin
							err_set = 1'b1;
						end
						hex_stop_d = 1'b0;
						saw_cr_d   = 1'b0;
						if (len_q == '0) begin
							phase_d   = PH_SIZE;
							taken_d   = '0;
							res_valid = 1'b1;
							res_kind  = KIND_END;
							res_last  = 1'b1;
						end else begin
							taken_d = '0;
							phase_d = PH_FIRST;
						end
					end else if (c.is_white) begin
						saw_cr_d = c.is_cr;
						phase_d  = PH_SIZE_LF;
					end else begin
						phase_d = PH_SIZE;
						if (!hex_stop_q && c.is_hex) begin
							// saturating accumulate of one hex digit
							if (len_q[SIZE_BITS-1 -: 4] != 4'd0) begin
								len_d = SIZE_MAX;
							end else begin
								len_d = {len_q[SIZE_BITS-5:0], c.hex_val};
							end
						end else begin
							hex_stop_d = 1'b1;
						end
					end
				end
				PH_FIRST, PH_DATA: begin
					if (phase_q == PH_FIRST && c.is_zero) begin
						phase_d = PH_DATA;
					end else begin
						taken_d   = taken_inc;
						phase_d   = (taken_inc >= len_q) ? PH_TRAIL_CR : PH_DATA;
						res_valid = 1'b1;
						res_byte  = c.data;
					end
				end
				PH_TRAIL_CR: begin
					saw_cr_d = c.is_cr;
					phase_d  = PH_TRAIL_LF;
				end
				PH_TRAIL_LF: begin
					if (!(saw_cr_q && c.is_lf)) begin
						err_set = 1'b1;
					end
					saw_cr_d = 1'b0;
					len_d    = '0;
					taken_d  = '0;
					if (stream_en) begin
						phase_d   = PH_AFTER_MARK;
						res_valid = 1'b1;
						res_kind  = KIND_MARK;
						res_byte  = CHR_LF;
					end else begin
						phase_d = PH_SIZE;
					end
				end
				default: begin
					phase_d    = PH_SIZE;
					len_d      = '0;
					taken_d    = '0;
					hex_stop_d = 1'b0;
					saw_cr_d   = 1'b0;
				end
			endcase
		end
		// pending framing error rides on the next chunked result
		res_err = chunked_en && (err_q || err_set);
		if (!chunked_en) begin
			err_d = err_q;
		end else if (res_valid) begin
			err_d = 1'b0;
		end else begin
			err_d = err_q || err_set;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SIZE;
			len_q      <= '0;
			taken_q    <= '0;
			hex_stop_q <= 1'b0;
			saw_cr_q   <= 1'b0;
			err_q      <= 1'b0;
		end else if (clear) begin
			phase_q    <= PH_SIZE;
			len_q      <= '0;
			taken_q    <= '0;
			hex_stop_q <= 1'b0;
			saw_cr_q   <= 1'b0;
			err_q      <= 1'b0;
		end else if (pop) begin
			phase_q    <= phase_d;
			len_q      <= len_d;
			taken_q    <= taken_d;
			hex_stop_q <= hex_stop_d;
			saw_cr_q   <= saw_cr_d;
			err_q      <= err_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_kind_q <= res_kind;
			out_byte_q <= res_byte;
			out_err_q  <= res_err;
			out_last_q <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_err_q, out_byte_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

>>> hw/rtl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Chunked transfer body decoder with a stream byte input, a stream result
// output and an APB-style register port.
// ----------------------------------------------------------------------------
// Takes one body byte per clock and gives at most one result per byte, at
// a sustained rate of one byte per cycle while the output is taken. A byte
// accepted from the input is written into the queue, and the parser takes it
// from the queue head once the output register is free or being emptied,
// loading its result into the output register, from which it is offered.
// The four-entry queue between the byte classifier and the parser absorbs
// output stalls. Results: m_tuser is the kind (0 data, 1 chunk end newline
// marker, 2 end of body), m_tdata holds the byte and the framing error flag,
// m_tlast marks end of body. Register 0 (address 0) enables chunked decoding
// and each write to it restarts the parser; register 1 (address 4) enables
// the chunk end markers. Write registers only while no byte is queued or in
// flight.
module http_chunked_body_decoder #(
	parameter int SIZE_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] framing_error, zero pad
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,   // is_last
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hcbd_pkg::*;

	logic  chunked_q;
	logic  stream_q;
	logic  cfg_wr;
	logic  cfg_clear;
	logic  q_full;
	logic  q_push;
	item_t q_in;
	logic  q_pop;
	logic  q_valid;
	item_t q_head;

	// register port
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign cfg_clear = cfg_wr && (paddr[2] == REG_CHUNKED);
	assign prdata    = (paddr[2] == REG_STREAM) ? {31'd0, stream_q} : {31'd0, chunked_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_q <= 1'b0;
			stream_q  <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_CHUNKED) begin
				chunked_q <= pwdata[0];
			end else begin
				stream_q <= pwdata[0];
			end
		end
	end

	hcbd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_in)
	);

	hcbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_head)
	);

	hcbd_back #(
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.chunked_en (chunked_q),
		.stream_en  (stream_q),
		.clear      (cfg_clear),
		.head_valid (q_valid),
		.head_item  (q_head),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

>>> hw/rtl/hcbd_checker.sv
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks of the chunked body decoder's result stream, bound to
// the top level.
// ----------------------------------------------------------------------------
module hcbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import hcbd_pkg::*;

	// end of body and tlast go together
	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == KIND_END)))
		else $error("tlast does not match end of body kind");

	// end of body carries a zero byte
	a_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_END) |-> (m_tdata[7:0] == 8'd0))
		else $error("end of body with nonzero byte");

	// chunk end marker carries the newline code
	a_mark_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_MARK) |-> (m_tdata[7:0] == CHR_LF))
		else $error("chunk end marker without newline");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
		(m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
		else $error("result changed while stalled");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
